/* src/blpi_pkg.sv */
// Shared constants, codes and types for the bounded list with positional insert.
package blpi_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 16;
  localparam int REQ_W      = 3;
  localparam int STAT_W     = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_INSERT     = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NEG_POS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP_FRONT
  } cell_op_e;

  // Broadcast to every cell; count is the entry count before the update.
  typedef struct packed {
    cell_op_e              op;
    logic [CNT_W-1:0]      at;
    logic [CNT_W-1:0]      count;
    logic [DATA_WIDTH-1:0] data;
  } cell_ctrl_t;

endpackage

/* src/blpi_cell.sv */
// One list cell: holds one entry and shifts toward either neighbor.
module blpi_cell import blpi_pkg::*; (
  input  logic                  clk_i,
  input  logic [CNT_W-1:0]      cell_idx_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [CNT_W-1:0]      count_i,
  output logic [DATA_WIDTH-1:0] val_o,
  output logic [DATA_WIDTH-1:0] back_o
);

  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [CNT_W-1:0]      idx_next;

  assign idx_next = cell_idx_i + CNT_W'(1);

  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (cell_idx_i == ctrl_i.at) begin
          val_d = ctrl_i.data;
        end else if (cell_idx_i > ctrl_i.at && cell_idx_i <= ctrl_i.count) begin
          val_d = left_i;
        end
      end
      CELL_POP_FRONT: begin
        if (idx_next < ctrl_i.count) begin
          val_d = right_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o  = val_q;
  assign back_o = (idx_next == count_i) ? val_q : '0;

endmodule

/* src/bounded_list_with_positional_insert_top.sv */
// Top level: request decode, cell chain and result register of the bounded list.
// For each request the cell chain shifts all entries in parallel at the accepting
// edge, and the next edge registers the count and the front and back values read
// from the chain. busy is high for the one cycle in between, and no new request is
// accepted while busy is high. busy falls at the edge that puts the result on the
// ports, with result_valid_o high for exactly one cycle; it cannot be held off.
module bounded_list_with_positional_insert_top import blpi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [DATA_WIDTH-1:0] item_value_i,
  input  logic [POS_W-1:0]      position_i,
  output logic                  result_valid_o,
  output logic [STAT_W-1:0]     status_o,
  output logic [CNT_W-1:0]      entry_count_o,
  output logic                  not_empty_o,
  output logic [DATA_WIDTH-1:0] front_value_o,
  output logic [DATA_WIDTH-1:0] back_value_o
);

  typedef enum logic {
    S_IDLE,
    S_REPORT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q, count_d;
  status_e          stat_q, stat_d;
  cell_ctrl_t       ctrl;
  logic             accept;
  logic             is_full, is_empty, pos_neg, pos_past;
  logic [CNT_W-1:0] ins_at;

  logic [DATA_WIDTH-1:0] cell_val  [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_back [CAPACITY];
  logic [DATA_WIDTH-1:0] back_or;

  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q == S_REPORT);
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign pos_neg  = position_i[POS_W-1];
  assign pos_past = ({1'b0, position_i[POS_W-2:0]} >= POS_W'(count_q));

  always_comb begin
    if (position_i == '0 || is_empty) begin
      ins_at = '0;
    end else if (pos_past) begin
      ins_at = count_q;
    end else begin
      ins_at = position_i[CNT_W-1:0];
    end
  end

  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.at    = '0;
    ctrl.count = count_q;
    ctrl.data  = item_value_i;
    count_d    = count_q;
    stat_d     = ST_DONE;
    case (req_type_i)
      REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
        if (req_type_i == REQ_INSERT && pos_neg) begin
          stat_d = ST_NEG_POS;
        end else if (is_full) begin
          stat_d = ST_FULL;
        end else begin
          ctrl.op = CELL_INSERT;
          count_d = count_q + CNT_W'(1);
          case (req_type_i)
            REQ_PUSH_FRONT: ctrl.at = '0;
            REQ_PUSH_BACK:  ctrl.at = count_q;
            default:        ctrl.at = ins_at;
          endcase
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (is_empty) begin
          stat_d = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
          if (req_type_i == REQ_POP_FRONT) begin
            ctrl.op = CELL_POP_FRONT;
          end
        end
      end
      default: ;
    endcase
    if (!accept) begin
      ctrl.op = CELL_HOLD;
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_v, right_v;
    if (k == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[k+1];
    end
    blpi_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (CNT_W'(k)),
      .ctrl_i     (ctrl),
      .left_i     (left_v),
      .right_i    (right_v),
      .count_i    (count_q),
      .val_o      (cell_val[k]),
      .back_o     (cell_back[k])
    );
  end

  always_comb begin
    back_or = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      back_or = back_or | cell_back[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      stat_q         <= ST_DONE;
      result_valid_o <= 1'b0;
      status_o       <= '0;
      entry_count_o  <= '0;
      not_empty_o    <= 1'b0;
      front_value_o  <= '0;
      back_value_o   <= '0;
    end else begin
      result_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            count_q <= count_d;
            stat_q  <= stat_d;
            state_q <= S_REPORT;
          end
        end
        S_REPORT: begin
          result_valid_o <= 1'b1;
          status_o       <= stat_q;
          entry_count_o  <= count_q;
          not_empty_o    <= !is_empty;
          front_value_o  <= is_empty ? '0 : cell_val[0];
          back_value_o   <= back_or;
          state_q        <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/tb_bounded_list_with_positional_insert_top.sv */
// Self-checking testbench: directed, full-list and random requests against a queue-based list model.
module tb_bounded_list_with_positional_insert_top import blpi_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 880;

  typedef struct packed {
    status_e               status;
    logic [CNT_W-1:0]      count;
    logic                  not_empty;
    logic [DATA_WIDTH-1:0] front;
    logic [DATA_WIDTH-1:0] back;
  } list_view_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  start        = 1'b0;
  logic                  busy;
  logic [REQ_W-1:0]      req_type_i   = '0;
  logic [DATA_WIDTH-1:0] item_value_i = '0;
  logic [POS_W-1:0]      position_i   = '0;
  logic                  result_valid_o;
  logic [STAT_W-1:0]     status_o;
  logic [CNT_W-1:0]      entry_count_o;
  logic                  not_empty_o;
  logic [DATA_WIDTH-1:0] front_value_o;
  logic [DATA_WIDTH-1:0] back_value_o;

  logic [DATA_WIDTH-1:0] shadow_list[$];
  list_view_t            pending_views[$];
  int unsigned           error_count  = 0;
  int unsigned           stall_cycles = 0;
  bit                    no_gaps      = 1'b0;

  always #2 clk_i = ~clk_i;

  bounded_list_with_positional_insert_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .item_value_i   (item_value_i),
    .position_i     (position_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o),
    .not_empty_o    (not_empty_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o)
  );

  // Applies one request to the shadow list and returns the view after it.
  function automatic list_view_t apply_request(logic [REQ_W-1:0] req,
                                               logic [DATA_WIDTH-1:0] val,
                                               logic [POS_W-1:0] pos);
    list_view_t v;
    int         at;
    v.status = ST_DONE;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
        if (req == REQ_INSERT && pos[POS_W-1]) begin
          v.status = ST_NEG_POS;
        end else if (shadow_list.size() >= CAPACITY) begin
          v.status = ST_FULL;
        end else begin
          if (req == REQ_PUSH_FRONT) at = 0;
          else if (req == REQ_PUSH_BACK) at = shadow_list.size();
          else if (pos == '0 || shadow_list.size() == 0) at = 0;
          else if (int'(pos) >= shadow_list.size()) at = shadow_list.size();
          else at = int'(pos);
          shadow_list.insert(at, val);
        end
      end
      REQ_POP_FRONT: begin
        if (shadow_list.size() == 0) v.status = ST_EMPTY;
        else shadow_list.delete(0);
      end
      REQ_POP_BACK: begin
        if (shadow_list.size() == 0) v.status = ST_EMPTY;
        else shadow_list.delete(shadow_list.size() - 1);
      end
      default: ;
    endcase
    v.count     = CNT_W'(shadow_list.size());
    v.not_empty = (shadow_list.size() != 0);
    v.front     = (shadow_list.size() != 0) ? shadow_list[0] : '0;
    v.back      = (shadow_list.size() != 0) ? shadow_list[$] : '0;
    return v;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Result check first, then prediction of the item accepted at this edge.
  always @(posedge clk_i) begin
    list_view_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_views.size() == 0) begin
          error_count++;
          $display("%0t unexpected result: expected none actual status %0h count %0d",
                   $time, status_o, entry_count_o);
        end else begin
          want = pending_views[0];
          pending_views.delete(0);
          check_field("status", 64'(want.status), 64'(status_o));
          check_field("entry_count", 64'(want.count), 64'(entry_count_o));
          check_field("not_empty", 64'(want.not_empty), 64'(not_empty_o));
          check_field("front_value", 64'(want.front), 64'(front_value_o));
          check_field("back_value", 64'(want.back), 64'(back_value_o));
        end
      end
      if (start && !busy)
        pending_views.insert(pending_views.size(),
                             apply_request(req_type_i, item_value_i, position_i));
      if (result_valid_o || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return $urandom;
  endfunction

  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Called at a falling edge; returns at a falling edge after the item is taken and an optional random idle gap.
  task automatic send_item(logic [REQ_W-1:0] req, logic [DATA_WIDTH-1:0] val,
                           logic [POS_W-1:0] pos);
    start        <= 1'b1;
    req_type_i   <= req;
    item_value_i <= val;
    position_i   <= pos;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
    idle_for(pick_gap());
  endtask

  task automatic test_directed_edges();
    send_item(REQ_POP_FRONT, $urandom, POS_W'($urandom));
    send_item(REQ_POP_BACK, $urandom, POS_W'($urandom));
    send_item(REQ_INSERT, 32'h1111_1111, 16'd5);
    send_item(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 16'h0000);
    send_item(REQ_PUSH_BACK, 32'h0000_0000, 16'hFFFF);
    send_item(REQ_INSERT, 32'h2222_2222, 16'd0);
    send_item(REQ_INSERT, 32'h3333_3333, 16'd4);
    send_item(REQ_INSERT, 32'h4444_4444, 16'h7FFF);
    send_item(REQ_INSERT, 32'h5555_5555, 16'd2);
    send_item(REQ_INSERT, 32'h6666_6666, 16'd1);
    send_item(REQ_INSERT, 32'h7777_7777, 16'hFFFF);
    send_item(REQ_INSERT, 32'h8888_8888, 16'h8000);
    send_item(REQ_INSERT, 32'h9999_9999, 16'd6);
    send_item(3'd5, $urandom, POS_W'($urandom));
    send_item(3'd6, $urandom, POS_W'($urandom));
    send_item(3'd7, $urandom, POS_W'($urandom));
    send_item(REQ_POP_FRONT, $urandom, POS_W'($urandom));
    send_item(REQ_POP_BACK, $urandom, POS_W'($urandom));
    send_item(REQ_POP_FRONT, $urandom, POS_W'($urandom));
    send_item(REQ_PUSH_BACK, 32'hA5A5_A5A5, 16'h8000);
    send_item(REQ_POP_BACK, $urandom, POS_W'($urandom));
  endtask

  task automatic test_full_list();
    logic [REQ_W-1:0] req;
    while (shadow_list.size() < CAPACITY) begin
      case ($urandom_range(2))
        0: req = REQ_PUSH_FRONT;
        1: req = REQ_PUSH_BACK;
        default: req = REQ_INSERT;
      endcase
      send_item(req, pick_value(), POS_W'($urandom_range(0, shadow_list.size() + 1)));
    end
    send_item(REQ_PUSH_FRONT, pick_value(), POS_W'($urandom));
    send_item(REQ_PUSH_BACK, pick_value(), POS_W'($urandom));
    send_item(REQ_INSERT, pick_value(), 16'd3);
    send_item(REQ_INSERT, pick_value(), 16'h7FFF);
    send_item(REQ_INSERT, pick_value(), 16'hFFFB);
    while (shadow_list.size() > 0)
      send_item($urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK, $urandom,
                POS_W'($urandom));
    send_item(REQ_POP_FRONT, $urandom, POS_W'($urandom));
    send_item(REQ_POP_BACK, $urandom, POS_W'($urandom));
  endtask

  task automatic test_random_mix();
    bit               grow;
    bit               add;
    int               r;
    int               p;
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    grow = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(3) == 0);
      if (shadow_list.size() >= CAPACITY) grow = 1'b0;
      if (shadow_list.size() == 0) grow = 1'b1;
      if ($urandom_range(63) == 0) grow = !grow;
      r   = $urandom_range(99);
      pos = POS_W'($urandom);
      if (r < 3) begin
        req = REQ_W'($urandom_range(5, 7));
      end else begin
        add = grow ? (r < 70) : (r < 30);
        if (add) begin
          case ($urandom_range(2))
            0: req = REQ_PUSH_FRONT;
            1: req = REQ_PUSH_BACK;
            default: begin
              req = REQ_INSERT;
              p   = $urandom_range(9);
              if (p == 1) pos = '0;
              else if (p == 2) pos = POS_W'(shadow_list.size());
              else if (p > 2) pos = POS_W'($urandom_range(0, shadow_list.size() + 1));
            end
          endcase
        end else begin
          req = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
        end
      end
      send_item(req, pick_value(), pos);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_edges();
    test_full_list();
    test_random_mix();
    start <= 1'b0;
    wait (pending_views.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
